// ===== hdl/erm_pkg.sv =====
// Shared widths, constants and register addresses for the energy/run-time meter.
package erm_pkg;

  localparam int ELAPSED_W = 8;
  localparam int TS_W      = 32;
  localparam int POWER_W   = 16;
  localparam int MINUTES_W = 32;
  localparam int TODAY_W   = 11;
  localparam int ENERGY_W  = 32;
  localparam int CAPPED_W  = 16;
  localparam int RESIDUE_W = 22;
  localparam int REM_W     = 6;
  localparam int INTERVAL_W = 16;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;

  localparam logic [TODAY_W-1:0]    DAY_CAP_MINUTES     = 11'd1440;
  localparam logic [TS_W-1:0]       SECONDS_PER_DAY     = 32'd86400;
  localparam logic [8:0]            SECONDS_PER_MINUTE  = 9'd60;
  localparam logic [24:0]           TENTH_KWH_UNITS     = 25'd3600000;
  localparam logic [INTERVAL_W-1:0] SAVE_INTERVAL_RESET = 16'd3600;
  localparam logic [CAPPED_W-1:0]   CAPPED_MAX          = 16'hFFFF;
  localparam logic [ENERGY_W-1:0]   ENERGY_MAX          = 32'hFFFF_FFFF;

  // Day index: now / 86400 = (now >> 7) / 675, done as a reciprocal multiply
  // that is exact for every 25-bit dividend.
  localparam int DAY_PRE_SHIFT   = 7;
  localparam int DAY_RECIP_SHIFT = 35;
  localparam int DAY_RECIP_W     = 26;
  localparam logic [63:0] DAY_RECIP_FULL =
    ((64'd1 << DAY_RECIP_SHIFT) + 64'd674) / 64'd675;
  localparam logic [DAY_RECIP_W-1:0] DAY_RECIP = DAY_RECIP_FULL[DAY_RECIP_W-1:0];
  localparam int DAY_NUM_W  = TS_W - DAY_PRE_SHIFT;
  localparam int DAY_PROD_W = DAY_NUM_W + DAY_RECIP_W;
  localparam int DAY_QUOT_W = 16;

  // Register byte addresses.
  localparam logic [PADDR_W-1:0] ADDR_SAVE_INTERVAL = 2'd0;

endpackage

// ===== hdl/erm_tick_if.sv =====
// Tick input channel: valid/ready handshake with the tick payload.
interface erm_tick_if import erm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ELAPSED_W-1:0] elapsed_s;
  logic [TS_W-1:0]      now_ts;
  logic                 clock_valid;
  logic                 unit_on;
  logic                 power_valid;
  logic [POWER_W-1:0]   load_power;

  modport source (
    output valid, elapsed_s, now_ts, clock_valid, unit_on, power_valid, load_power,
    input  ready
  );
  modport sink (
    input  valid, elapsed_s, now_ts, clock_valid, unit_on, power_valid, load_power,
    output ready
  );
endinterface

// ===== hdl/erm_result_if.sv =====
// Result channel: valid/ready handshake with the meter counters.
interface erm_result_if import erm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MINUTES_W-1:0] total_minutes;
  logic [TODAY_W-1:0]   today_minutes;
  logic [ENERGY_W-1:0]  energy_tenth_kwh;
  logic [CAPPED_W-1:0]  run_time_capped;
  logic                 save_now;

  modport source (
    output valid, total_minutes, today_minutes, energy_tenth_kwh, run_time_capped,
           save_now,
    input  ready
  );
  modport sink (
    input  valid, total_minutes, today_minutes, energy_tenth_kwh, run_time_capped,
           save_now,
    output ready
  );
endinterface

// ===== hdl/energy_runtime_meter.sv =====
// Energy and run-time meter top level.
//
// One tick transfer on the tick channel produces exactly one transfer on the
// result channel, in order. A tick carries elapsed seconds, the wall-clock
// time, clock/power valid flags, the unit on state and the load power.
// The result carries total and today's run minutes, energy in 0.1 kWh, the
// run time saturated to 16 bits and a save request.
// A tick passes the input register, the day-index multiply, the day-start
// multiply, then the counter update into the output register. Throughput: one
// tick per cycle while the result is not stalled; the counter update is a
// single registered pass, so back-to-back ticks do not wait on it.
// Every stage holds while the stage after it is full and stalled, so a
// stalled receiver keeps the result stable and ticks are still taken until
// the pipeline bubbles are used up.
// The APB port holds save_interval_s at address 0 (reset 3600); write it only
// while no tick is in flight.
// Reset (rst, synchronous) empties the pipeline and clears all counters, the
// day window and the last save time.
module energy_runtime_meter import erm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  erm_tick_if.sink            tick,
  erm_result_if.source        result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration
  logic [INTERVAL_W-1:0] save_interval;

  // pipeline stage valids and readies
  logic a_valid, b_valid, c_valid;
  logic a_ready, b_ready, c_ready, out_free, d_load;

  // stage A: input register
  logic [ELAPSED_W-1:0] a_elapsed;
  logic [TS_W-1:0]      a_now;
  logic                 a_clk_ok, a_on, a_pwr_ok;
  logic [POWER_W-1:0]   a_power;

  // stage B: day index and energy product
  logic [DAY_QUOT_W-1:0] b_quot;
  logic [23:0]           b_prod;
  logic [ELAPSED_W-1:0]  b_elapsed;
  logic [TS_W-1:0]       b_now;
  logic                  b_clk_ok, b_on, b_pwr_act;

  // stage C: day start
  logic [TS_W-1:0]      c_start;
  logic [23:0]          c_prod;
  logic [ELAPSED_W-1:0] c_elapsed;
  logic [TS_W-1:0]      c_now;
  logic                 c_clk_ok, c_on, c_pwr_act;

  logic [DAY_PROD_W-1:0] quot_prod;
  logic [TS_W-1:0]       start_prod;

  // meter state
  logic [MINUTES_W-1:0] run_minutes_acc, run_minutes_acc_next;
  logic [TODAY_W-1:0]   today_minutes_acc, today_minutes_acc_next;
  logic [REM_W-1:0]     second_remainder, second_remainder_next;
  logic [ENERGY_W-1:0]  energy_total, energy_total_next;
  logic [RESIDUE_W-1:0] energy_residue, energy_residue_next;
  logic [TS_W-1:0]      day_start_ts, day_start_ts_next;
  logic                 day_known, day_known_next;
  logic [TS_W-1:0]      last_save_time, last_save_time_next;
  logic                 save_req;

  // update logic
  logic [TS_W:0]        day_end, new_end;
  logic                 in_window, new_day, clear_today;
  logic [TODAY_W-1:0]   today_sync, today_clamp, today_room;
  logic [8:0]           secs;
  logic [2:0]           min_incr;
  logic [8:0]           secs_rem;
  logic [24:0]          e_acc;
  logic [2:0]           e_incr;
  logic [24:0]          e_rem;
  logic [ENERGY_W:0]    e_sum;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_SAVE_INTERVAL) ?
                  {{(PDATA_W-INTERVAL_W){1'b0}}, save_interval} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      save_interval <= SAVE_INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SAVE_INTERVAL) begin
      save_interval <= pwdata[INTERVAL_W-1:0];
    end
  end

  // ---------------- handshake ----------------
  assign out_free   = !result.valid || result.ready;
  assign c_ready    = !c_valid || out_free;
  assign b_ready    = !b_valid || c_ready;
  assign a_ready    = !a_valid || b_ready;
  assign tick.ready = a_ready;
  assign d_load     = c_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      c_valid      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= tick.valid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (out_free) result.valid <= c_valid;
    end
  end

  // ---------------- payload pipeline ----------------
  assign quot_prod  = DAY_PROD_W'(a_now[TS_W-1:DAY_PRE_SHIFT]) * DAY_PROD_W'(DAY_RECIP);
  assign start_prod = TS_W'(b_quot) * SECONDS_PER_DAY;

  always_ff @(posedge clk) begin
    if (tick.valid && a_ready) begin
      a_elapsed <= tick.elapsed_s;
      a_now     <= tick.now_ts;
      a_clk_ok  <= tick.clock_valid;
      a_on      <= tick.unit_on;
      a_pwr_ok  <= tick.power_valid;
      a_power   <= tick.load_power;
    end
    if (a_valid && b_ready) begin
      b_quot    <= quot_prod[DAY_PROD_W-1 -: DAY_QUOT_W];
      b_prod    <= 24'(a_power) * 24'(a_elapsed);
      b_elapsed <= a_elapsed;
      b_now     <= a_now;
      b_clk_ok  <= a_clk_ok;
      b_on      <= a_on;
      b_pwr_act <= a_pwr_ok && (a_power != '0);
    end
    if (b_valid && c_ready) begin
      c_start   <= start_prod;
      c_prod    <= b_prod;
      c_elapsed <= b_elapsed;
      c_now     <= b_now;
      c_clk_ok  <= b_clk_ok;
      c_on      <= b_on;
      c_pwr_act <= b_pwr_act;
    end
  end

  // ---------------- counter update ----------------
  always_comb begin
    // day window
    day_end     = {1'b0, day_start_ts} + (TS_W+1)'(SECONDS_PER_DAY);
    new_end     = {1'b0, c_start} + (TS_W+1)'(SECONDS_PER_DAY);
    in_window   = day_known && (c_now >= day_start_ts) && ({1'b0, c_now} < day_end);
    new_day     = c_clk_ok && !in_window;
    // on the first sync keep today's minutes if the last save falls in the day
    clear_today = new_day && (day_known || (last_save_time < c_start) ||
                              ({1'b0, last_save_time} >= new_end));
    today_sync  = clear_today ? '0 : today_minutes_acc;
    today_clamp = (today_sync > DAY_CAP_MINUTES) ? DAY_CAP_MINUTES : today_sync;
    today_room  = DAY_CAP_MINUTES - today_clamp;
    day_start_ts_next = new_day ? c_start : day_start_ts;
    day_known_next    = day_known || new_day;

    // run minutes
    secs = 9'(second_remainder) + 9'(c_elapsed);
    if (secs >= 9'(5) * SECONDS_PER_MINUTE) begin
      min_incr = 3'd5;
      secs_rem = secs - 9'(5) * SECONDS_PER_MINUTE;
    end else if (secs >= 9'(4) * SECONDS_PER_MINUTE) begin
      min_incr = 3'd4;
      secs_rem = secs - 9'(4) * SECONDS_PER_MINUTE;
    end else if (secs >= 9'(3) * SECONDS_PER_MINUTE) begin
      min_incr = 3'd3;
      secs_rem = secs - 9'(3) * SECONDS_PER_MINUTE;
    end else if (secs >= 9'(2) * SECONDS_PER_MINUTE) begin
      min_incr = 3'd2;
      secs_rem = secs - 9'(2) * SECONDS_PER_MINUTE;
    end else if (secs >= SECONDS_PER_MINUTE) begin
      min_incr = 3'd1;
      secs_rem = secs - SECONDS_PER_MINUTE;
    end else begin
      min_incr = 3'd0;
      secs_rem = secs;
    end

    if (c_on) begin
      run_minutes_acc_next   = run_minutes_acc + MINUTES_W'(min_incr);
      today_minutes_acc_next = (TODAY_W'(min_incr) >= today_room) ? DAY_CAP_MINUTES :
                               today_clamp + TODAY_W'(min_incr);
      second_remainder_next  = secs_rem[REM_W-1:0];
    end else begin
      run_minutes_acc_next   = run_minutes_acc;
      today_minutes_acc_next = today_clamp;
      second_remainder_next  = second_remainder;
    end

    // energy
    e_acc = 25'(energy_residue) + 25'(c_prod);
    if (e_acc >= 25'(5) * TENTH_KWH_UNITS) begin
      e_incr = 3'd5;
      e_rem  = e_acc - 25'(5) * TENTH_KWH_UNITS;
    end else if (e_acc >= 25'(4) * TENTH_KWH_UNITS) begin
      e_incr = 3'd4;
      e_rem  = e_acc - 25'(4) * TENTH_KWH_UNITS;
    end else if (e_acc >= 25'(3) * TENTH_KWH_UNITS) begin
      e_incr = 3'd3;
      e_rem  = e_acc - 25'(3) * TENTH_KWH_UNITS;
    end else if (e_acc >= 25'(2) * TENTH_KWH_UNITS) begin
      e_incr = 3'd2;
      e_rem  = e_acc - 25'(2) * TENTH_KWH_UNITS;
    end else if (e_acc >= TENTH_KWH_UNITS) begin
      e_incr = 3'd1;
      e_rem  = e_acc - TENTH_KWH_UNITS;
    end else begin
      e_incr = 3'd0;
      e_rem  = e_acc;
    end
    e_sum = {1'b0, energy_total} + (ENERGY_W+1)'(e_incr);

    if (c_pwr_act) begin
      energy_residue_next = e_rem[RESIDUE_W-1:0];
      energy_total_next   = e_sum[ENERGY_W] ? ENERGY_MAX : e_sum[ENERGY_W-1:0];
    end else begin
      energy_residue_next = energy_residue;
      energy_total_next   = energy_total;
    end

    // save request; re-anchor on zero or backward time
    save_req            = 1'b0;
    last_save_time_next = last_save_time;
    if (c_clk_ok) begin
      if (last_save_time == '0 || c_now < last_save_time) begin
        last_save_time_next = c_now;
      end else if (c_now - last_save_time >= TS_W'(save_interval)) begin
        last_save_time_next = c_now;
        save_req            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_minutes_acc   <= '0;
      today_minutes_acc <= '0;
      second_remainder  <= '0;
      energy_total      <= '0;
      energy_residue    <= '0;
      day_start_ts      <= '0;
      day_known         <= 1'b0;
      last_save_time    <= '0;
    end else if (d_load) begin
      run_minutes_acc   <= run_minutes_acc_next;
      today_minutes_acc <= today_minutes_acc_next;
      second_remainder  <= second_remainder_next;
      energy_total      <= energy_total_next;
      energy_residue    <= energy_residue_next;
      day_start_ts      <= day_start_ts_next;
      day_known         <= day_known_next;
      last_save_time    <= last_save_time_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (d_load) begin
      result.total_minutes    <= run_minutes_acc_next;
      result.today_minutes    <= today_minutes_acc_next;
      result.energy_tenth_kwh <= energy_total_next;
      result.run_time_capped  <= (run_minutes_acc_next > MINUTES_W'(CAPPED_MAX)) ?
                                 CAPPED_MAX : run_minutes_acc_next[CAPPED_W-1:0];
      result.save_now         <= save_req;
    end
  end

  // ---------------- assertions ----------------
  a_today_capped: assert property (@(posedge clk) disable iff (rst)
    today_minutes_acc <= DAY_CAP_MINUTES)
    else $error("today minutes above the day cap");

  a_second_rem: assert property (@(posedge clk) disable iff (rst)
    6'(second_remainder) < SECONDS_PER_MINUTE[REM_W-1:0])
    else $error("second remainder reached a full minute");

  a_energy_rem: assert property (@(posedge clk) disable iff (rst)
    25'(energy_residue) < TENTH_KWH_UNITS)
    else $error("energy residue reached a full 0.1 kWh");

  a_day_sticky: assert property (@(posedge clk) disable iff (rst)
    day_known |=> day_known)
    else $error("day sync lost without reset");

  a_save_anchor: assert property (@(posedge clk) disable iff (rst)
    d_load && save_req |=> last_save_time == $past(c_now) && result.valid && result.save_now)
    else $error("save request without re-anchored save time");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the energy and run-time meter.
module testbench;
  import erm_pkg::*;

  typedef struct packed {
    logic [ELAPSED_W-1:0] elapsed_s;
    logic [TS_W-1:0]      now_ts;
    logic                 clock_valid;
    logic                 unit_on;
    logic                 power_valid;
    logic [POWER_W-1:0]   load_power;
  } tick_t;

  typedef struct packed {
    logic [MINUTES_W-1:0] total_minutes;
    logic [TODAY_W-1:0]   today_minutes;
    logic [ENERGY_W-1:0]  energy_tenth_kwh;
    logic [CAPPED_W-1:0]  run_time_capped;
    logic                 save_now;
  } meter_reading_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  erm_tick_if   tick ();
  erm_result_if result ();

  energy_runtime_meter dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Meter state mirrored by the predictor.
  logic [INTERVAL_W-1:0] save_interval;
  logic [MINUTES_W-1:0]  run_min;
  logic [TODAY_W-1:0]    today_min;
  logic [REM_W-1:0]      sec_rem;
  logic [ENERGY_W-1:0]   energy;
  logic [RESIDUE_W-1:0]  energy_res;
  logic [TS_W-1:0]       day_start;
  logic                  day_synced;
  logic [TS_W-1:0]       last_save;

  meter_reading_t expected_readings[$];

  int tx_idle_max;
  int rx_idle_max;
  int rx_hold;
  int error_count;
  int mismatch_count;
  int ticks_sent;
  int readings_checked;
  int saves_seen;
  int settings_used;
  logic [TS_W-1:0] wall_ts;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic meter_reading_t meter_advance(tick_t t);
    logic [TS_W:0]   day_end;
    logic [TS_W-1:0] new_start;
    int unsigned     secs;
    int unsigned     incr;
    longint unsigned acc;
    longint unsigned e_incr;
    meter_reading_t  r;
    r = '0;
    if (t.clock_valid) begin
      day_end = {1'b0, day_start} + {1'b0, SECONDS_PER_DAY};
      if (!(day_synced && t.now_ts >= day_start && {1'b0, t.now_ts} < day_end)) begin
        new_start = t.now_ts - (t.now_ts % SECONDS_PER_DAY);
        day_end = {1'b0, new_start} + {1'b0, SECONDS_PER_DAY};
        // On the first sync keep today's minutes if the last save falls in the new day.
        if (day_synced || last_save < new_start || {1'b0, last_save} >= day_end) begin
          today_min = '0;
        end
        day_start = new_start;
        day_synced = 1'b1;
      end
    end
    if (today_min > DAY_CAP_MINUTES) today_min = DAY_CAP_MINUTES;
    if (t.unit_on) begin
      secs = sec_rem + t.elapsed_s;
      incr = secs / SECONDS_PER_MINUTE;
      run_min = run_min + incr;
      if (incr >= DAY_CAP_MINUTES - today_min) begin
        today_min = DAY_CAP_MINUTES;
      end else begin
        today_min = today_min + TODAY_W'(incr);
      end
      sec_rem = REM_W'(secs % SECONDS_PER_MINUTE);
    end
    if (t.power_valid && t.load_power != '0) begin
      acc = energy_res + t.load_power * t.elapsed_s;
      e_incr = acc / TENTH_KWH_UNITS;
      energy_res = RESIDUE_W'(acc % TENTH_KWH_UNITS);
      if (64'(ENERGY_MAX) - energy < e_incr) begin
        energy = ENERGY_MAX;
      end else begin
        energy = energy + ENERGY_W'(e_incr);
      end
    end
    if (t.clock_valid) begin
      // Re-anchor on a zero anchor or on time running backward.
      if (last_save == '0 || t.now_ts < last_save) begin
        last_save = t.now_ts;
      end else if (t.now_ts - last_save >= save_interval) begin
        last_save = t.now_ts;
        r.save_now = 1'b1;
      end
    end
    r.total_minutes = run_min;
    r.today_minutes = today_min;
    r.energy_tenth_kwh = energy;
    r.run_time_capped = (run_min > 32'(CAPPED_MAX)) ? CAPPED_MAX : run_min[CAPPED_W-1:0];
    return r;
  endfunction

  function automatic tick_t make_tick(int unsigned el, logic [TS_W-1:0] ts, bit cv, bit on,
                                      bit pv, int unsigned pw);
    tick_t t;
    t.elapsed_s = ELAPSED_W'(el);
    t.now_ts = ts;
    t.clock_valid = cv;
    t.unit_on = on;
    t.power_valid = pv;
    t.load_power = POWER_W'(pw);
    return t;
  endfunction

  // Mostly a clock that runs forward with the elapsed seconds, with jumps mixed in.
  function automatic tick_t random_tick();
    tick_t t;
    int    k;
    k = $urandom_range(99, 0);
    if (k < 5) t.elapsed_s = '0;
    else if (k < 80) t.elapsed_s = ELAPSED_W'($urandom_range(5, 1));
    else t.elapsed_s = ELAPSED_W'($urandom_range(255, 0));
    wall_ts = wall_ts + t.elapsed_s;
    k = $urandom_range(99, 0);
    if (k < 4) wall_ts = $urandom();
    else if (k < 8) wall_ts = wall_ts - $urandom_range(5000, 1);
    else if (k < 12) wall_ts = wall_ts + SECONDS_PER_DAY * $urandom_range(3, 1);
    else if (k < 14) wall_ts = 32'hFFFF_FFFF - $urandom_range(200000, 0);
    t.now_ts = wall_ts;
    t.clock_valid = ($urandom_range(9, 0) != 0);
    t.unit_on = ($urandom_range(3, 0) != 0);
    t.power_valid = ($urandom_range(4, 0) != 0);
    t.load_power = ($urandom_range(9, 0) == 0) ? '0 : POWER_W'($urandom_range(65535, 0));
    return t;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  task automatic compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  always @(posedge clk) begin
    meter_reading_t want;
    if (!rst && result.valid === 1'b1 && result.ready === 1'b1) begin
      if (expected_readings.size() == 0) begin
        note_mismatch("unexpected result transfer", 0, 1);
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (want.save_now) saves_seen++;
        compare_field("total_minutes", want.total_minutes, result.total_minutes);
        compare_field("today_minutes", want.today_minutes, result.today_minutes);
        compare_field("energy_tenth_kwh", want.energy_tenth_kwh, result.energy_tenth_kwh);
        compare_field("run_time_capped", want.run_time_capped, result.run_time_capped);
        compare_field("save_now", want.save_now, result.save_now);
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when requested.
  initial begin
    int w;
    result.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (rx_hold > 0) begin
        w = rx_hold;
        rx_hold = 0;
      end else begin
        w = $urandom_range(rx_idle_max, 0);
      end
      if (w > 0) begin
        result.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!(result.valid === 1'b1 && result.ready === 1'b1));
    end
  end

  task automatic send_tick(tick_t t);
    int gap;
    gap = $urandom_range(tx_idle_max, 0);
    if (gap > 0) begin
      tick.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick.valid <= 1'b1;
    tick.elapsed_s <= t.elapsed_s;
    tick.now_ts <= t.now_ts;
    tick.clock_valid <= t.clock_valid;
    tick.unit_on <= t.unit_on;
    tick.power_valid <= t.power_valid;
    tick.load_power <= t.load_power;
    do @(posedge clk); while (tick.ready !== 1'b1);
    expected_readings.push_back(meter_advance(t));
    ticks_sent++;
  endtask

  // Stop offering ticks until every expected result has been taken.
  task automatic drain();
    tick.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic apb_transfer(bit is_write, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= ADDR_SAVE_INTERVAL;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_interval_reg();
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b0, '0, rd);
    compare_field("save_interval_s readback", {16'b0, save_interval}, rd);
  endtask

  task automatic set_save_interval(logic [INTERVAL_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    drain();
    apb_transfer(1'b1, {16'b0, value}, rd);
    save_interval = value;
    settings_used++;
    check_interval_reg();
  endtask

  task automatic test_directed_ticks();
    tx_idle_max = 6;
    rx_idle_max = 6;
    check_interval_reg();
    send_tick(make_tick(0, 0, 0, 0, 0, 0));
    send_tick(make_tick(255, 0, 0, 1, 1, 65535));
    send_tick(make_tick(255, 32'hFFFF_FFFF, 0, 1, 0, 65535));
    send_tick(make_tick(120, 0, 0, 0, 1, 0));
    // first sync with the last save inside day zero keeps today's minutes
    send_tick(make_tick(1, 1000, 1, 1, 1, 1000));
    send_tick(make_tick(0, 1030, 1, 0, 0, 0));
    send_tick(make_tick(1, 4600, 1, 1, 1, 5));
    send_tick(make_tick(1, 500, 1, 1, 1, 1));
    send_tick(make_tick(60, SECONDS_PER_DAY * 3 + 7, 1, 1, 1, 65535));
    // last day of the timestamp range
    send_tick(make_tick(60, 32'hFFFF_FFFF, 1, 1, 1, 1));
    send_tick(make_tick(60, 32'hFFFF_FFFE, 1, 1, 1, 1));
    send_tick(make_tick(255, 32'hFFFF_FFFF, 1, 1, 1, 65535));
    send_tick(make_tick(0, 0, 1, 0, 0, 0));
    send_tick(make_tick(0, 0, 1, 0, 0, 0));
  endtask

  task automatic test_interval_extremes();
    tx_idle_max = 0;
    rx_idle_max = 0;
    set_save_interval(16'd0);
    send_tick(make_tick(1, 5000, 1, 1, 0, 0));
    send_tick(make_tick(1, 5000, 1, 1, 0, 0));
    send_tick(make_tick(1, 5001, 1, 1, 0, 0));
    set_save_interval(16'd1);
    send_tick(make_tick(1, 5001, 1, 1, 0, 0));
    send_tick(make_tick(1, 5002, 1, 1, 0, 0));
    set_save_interval(16'hFFFF);
    send_tick(make_tick(1, 5002 + 65534, 1, 1, 0, 0));
    send_tick(make_tick(1, 5002 + 65535, 1, 1, 0, 0));
    send_tick(make_tick(0, 5002 + 65535, 0, 0, 0, 0));
  endtask

  // Run the unit through a whole day so today's minutes reach the cap.
  task automatic test_day_cap();
    tick_t t;
    tx_idle_max = 2;
    rx_idle_max = 2;
    set_save_interval(16'd600);
    wall_ts = SECONDS_PER_DAY * 10 + 5;
    for (int i = 0; i < 380; i++) begin
      t = random_tick();
      t.elapsed_s = ELAPSED_W'(240 + $urandom_range(15, 0));
      t.now_ts = SECONDS_PER_DAY * 10 + 5 + i * 200;
      t.clock_valid = 1'b1;
      t.unit_on = 1'b1;
      send_tick(t);
    end
    send_tick(make_tick(0, SECONDS_PER_DAY * 11 + 1, 1, 0, 0, 0));
  endtask

  task automatic test_random_mix();
    int tx_modes[5] = '{6, 0, 6, 0, 3};
    int rx_modes[5] = '{6, 0, 0, 6, 6};
    logic [INTERVAL_W-1:0] intervals[5];
    intervals = '{16'd1, 16'hFFFF, INTERVAL_W'($urandom_range(65535, 1)), 16'd60, 16'd3600};
    wall_ts = $urandom();
    for (int p = 0; p < 5; p++) begin
      set_save_interval(intervals[p]);
      tx_idle_max = tx_modes[p];
      rx_idle_max = rx_modes[p];
      repeat (100) send_tick(random_tick());
    end
  endtask

  task automatic test_backpressure();
    set_save_interval(INTERVAL_W'($urandom_range(300, 1)));
    tx_idle_max = 0;
    rx_idle_max = 3;
    rx_hold = 150;
    repeat (40) send_tick(random_tick());
    drain();
    repeat (20) send_tick(random_tick());
  endtask

  // Finish with random ticks at the reset save interval.
  task automatic test_random_tail();
    set_save_interval(16'd3600);
    tx_idle_max = 6;
    rx_idle_max = 6;
    repeat (50) send_tick(random_tick());
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    tick.valid <= 1'b0;
    tick.elapsed_s <= '0;
    tick.now_ts <= '0;
    tick.clock_valid <= 1'b0;
    tick.unit_on <= 1'b0;
    tick.power_valid <= 1'b0;
    tick.load_power <= '0;
    save_interval = SAVE_INTERVAL_RESET;
    run_min = '0;
    today_min = '0;
    sec_rem = '0;
    energy = '0;
    energy_res = '0;
    day_start = '0;
    day_synced = 1'b0;
    last_save = '0;
    tx_idle_max = 0;
    rx_idle_max = 0;
    rx_hold = 0;
    error_count = 0;
    mismatch_count = 0;
    ticks_sent = 0;
    readings_checked = 0;
    saves_seen = 0;
    settings_used = 0;
    wall_ts = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ticks();
    test_interval_extremes();
    test_day_cap();
    test_random_mix();
    test_backpressure();
    test_random_tail();

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d ticks, checked %0d readings (%0d with a save request)",
             ticks_sent, readings_checked, saves_seen);
    $display("Used %0d save interval settings, day rollover, cap and long stall cases",
             settings_used);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/erm_pkg.sv
hdl/erm_tick_if.sv
hdl/erm_result_if.sv
hdl/energy_runtime_meter.sv
bench/testbench.sv
